// ===== design/assert_macros.svh =====
// assertion macros shared by the pipe table rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

// ===== design/mpbf_pkg.sv =====
// types and constants of the byte pipe table
// no dependencies
`timescale 1ns / 1ps

package mpbf_pkg;

	localparam int NUM_PIPES_DEF  = 8;
	localparam int PIPE_BYTES_DEF = 256;

	localparam int CMD_W   = 3;
	localparam int INDEX_W = 4;
	localparam int DATA_W  = 8;
	localparam int STAT_W  = 3;
	localparam int NEWIX_W = 3;
	localparam int REF_W   = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE  = 3'd0,
		CMD_READ    = 3'd1,
		CMD_WRITE   = 3'd2,
		CMD_CLOSE   = 3'd3,
		CMD_ADD_REF = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_BLOCK   = 3'd1,
		ST_EOD     = 3'd2,
		ST_SHORT   = 3'd3,
		ST_INVALID = 3'd4,
		ST_BROKEN  = 3'd5,
		ST_NOFREE  = 3'd6
	} status_t;

	localparam logic [REF_W-1:0] REF_MAX = '1;

endpackage

// ===== design/mpbf_in_if.sv =====
// command channel of the byte pipe table
// depends on mpbf_pkg
`timescale 1ns / 1ps

interface mpbf_in_if;
	import mpbf_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [INDEX_W-1:0] pipe_index;
	logic [DATA_W-1:0]  write_data;
	logic               end_is_write;
	logic               first_byte;

	modport source (
		output valid, command, pipe_index, write_data, end_is_write, first_byte,
		input  ready
	);
	modport sink (
		input  valid, command, pipe_index, write_data, end_is_write, first_byte,
		output ready
	);
endinterface

// ===== design/mpbf_out_if.sv =====
// result channel of the byte pipe table
// depends on mpbf_pkg
`timescale 1ns / 1ps

interface mpbf_out_if;
	import mpbf_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [NEWIX_W-1:0] new_index;
	logic [DATA_W-1:0]  read_data;

	modport source (
		output valid, status, new_index, read_data,
		input  ready
	);
	modport sink (
		input  valid, status, new_index, read_data,
		output ready
	);
endinterface

// ===== design/multi_pipe_byte_fifo_table_top.sv =====
// byte pipe table top level: command decode, per pipe state, result register
// depends on mpbf_pkg, mpbf_in_if, mpbf_out_if, mpbf_store, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A table of NUM_PIPES byte pipes, each a ring of PIPE_BYTES bytes in one
// shared single port memory. Every command transaction gives exactly one
// result transaction in the cycle after it is taken; a new command is taken each
// cycle while the result register is empty or being drained, so the table
// runs at one command per cycle, bound by the single port of the byte memory
// (one read or one write per cycle). Pipe pointers, fill levels and reference
// counts sit in registers cleared by reset; the byte memory needs no clearing.
module multi_pipe_byte_fifo_table_top #(
	parameter int NUM_PIPES  = mpbf_pkg::NUM_PIPES_DEF,
	parameter int PIPE_BYTES = mpbf_pkg::PIPE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mpbf_in_if.sink    request,
	mpbf_out_if.source response
);
	import mpbf_pkg::*;

	localparam int IDX_W  = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int PTR_W  = $clog2(PIPE_BYTES);
	localparam int CNT_W  = $clog2(PIPE_BYTES + 1);
	localparam int DEPTH  = NUM_PIPES * PIPE_BYTES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [NUM_PIPES-1:0] in_use_q;
	logic [PTR_W-1:0]     wp_q [NUM_PIPES];
	logic [PTR_W-1:0]     rp_q [NUM_PIPES];
	logic [CNT_W-1:0]     fill_q [NUM_PIPES];
	logic [REF_W-1:0]     rref_q [NUM_PIPES];
	logic [REF_W-1:0]     wref_q [NUM_PIPES];

	logic               valid_s1;
	status_t            status_s1;
	logic [NEWIX_W-1:0] new_index_s1;
	logic               rd_ok_s1;

	logic               accept;
	logic [IDX_W-1:0]   idx;
	logic               sel_ok;
	logic               free_found;
	logic [IDX_W-1:0]   free_idx;
	logic [PTR_W-1:0]   rp_sel;
	logic [PTR_W-1:0]   wp_sel;
	logic [CNT_W-1:0]   fill_sel;
	logic [REF_W-1:0]   rref_sel;
	logic [REF_W-1:0]   wref_sel;
	logic [REF_W-1:0]   rref_nxt;
	logic [REF_W-1:0]   wref_nxt;
	status_t            st;
	logic               do_create;
	logic               do_read;
	logic               do_write;
	logic               do_close;
	logic               do_ref;
	logic               mem_en;
	logic               mem_we;
	logic [PTR_W-1:0]   mem_ptr;
	logic [ADDR_W-1:0]  mem_addr;
	logic [DATA_W-1:0]  mem_rdata;

	assign request.ready = !valid_s1 || response.ready;
	assign accept        = request.valid && request.ready;

	assign idx      = request.pipe_index[IDX_W-1:0];
	assign sel_ok   = ({1'b0, request.pipe_index} < (INDEX_W+1)'(NUM_PIPES)) && in_use_q[idx];
	assign rp_sel   = rp_q[idx];
	assign wp_sel   = wp_q[idx];
	assign fill_sel = fill_q[idx];
	assign rref_sel = rref_q[idx];
	assign wref_sel = wref_q[idx];

	// lowest free pipe
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_PIPES - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// reference counts after close or add reference
	always_comb begin
		rref_nxt = rref_sel;
		wref_nxt = wref_sel;
		if (do_close) begin
			if (request.end_is_write) begin
				if (wref_sel != '0) wref_nxt = wref_sel - 1'b1;
			end else begin
				if (rref_sel != '0) rref_nxt = rref_sel - 1'b1;
			end
		end else if (do_ref) begin
			if (request.end_is_write) begin
				if (wref_sel != REF_MAX) wref_nxt = wref_sel + 1'b1;
			end else begin
				if (rref_sel != REF_MAX) rref_nxt = rref_sel + 1'b1;
			end
		end
	end

	always_comb begin
		st        = ST_OK;
		do_create = 1'b0;
		do_read   = 1'b0;
		do_write  = 1'b0;
		do_close  = 1'b0;
		do_ref    = 1'b0;
		unique case (request.command)
			CMD_CREATE: begin
				if (free_found) do_create = 1'b1;
				else st = ST_NOFREE;
			end
			CMD_READ: begin
				if (!sel_ok) st = ST_INVALID;
				else if (fill_sel == '0) begin
					if (!request.first_byte) st = ST_SHORT;
					else if (wref_sel == '0) st = ST_EOD;
					else st = ST_BLOCK;
				end else do_read = 1'b1;
			end
			CMD_WRITE: begin
				if (!sel_ok) st = ST_INVALID;
				else if (rref_sel == '0) st = ST_BROKEN;
				else if (fill_sel >= CNT_W'(PIPE_BYTES)) st = ST_BLOCK;
				else do_write = 1'b1;
			end
			CMD_CLOSE: begin
				if (!sel_ok) st = ST_INVALID;
				else do_close = 1'b1;
			end
			CMD_ADD_REF: begin
				if (!sel_ok) st = ST_INVALID;
				else do_ref = 1'b1;
			end
			default: st = ST_INVALID;
		endcase
	end

	assign mem_en   = accept && (do_read || do_write);
	assign mem_we   = do_write;
	assign mem_ptr  = do_write ? wp_sel : rp_sel;
	assign mem_addr = ADDR_W'(idx) * ADDR_W'(PIPE_BYTES) + ADDR_W'(mem_ptr);

	mpbf_store #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(request.write_data),
		.rdata(mem_rdata)
	);

	// per pipe state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			for (int i = 0; i < NUM_PIPES; i++) begin
				wp_q[i]   <= '0;
				rp_q[i]   <= '0;
				fill_q[i] <= '0;
				rref_q[i] <= '0;
				wref_q[i] <= '0;
			end
		end else if (accept) begin
			if (do_create) begin
				in_use_q[free_idx] <= 1'b1;
				wp_q[free_idx]     <= '0;
				rp_q[free_idx]     <= '0;
				fill_q[free_idx]   <= '0;
				rref_q[free_idx]   <= REF_W'(1);
				wref_q[free_idx]   <= REF_W'(1);
			end
			if (do_read) begin
				rp_q[idx]   <= (rp_sel == PTR_W'(PIPE_BYTES - 1)) ? '0 : rp_sel + 1'b1;
				fill_q[idx] <= fill_sel - 1'b1;
			end
			if (do_write) begin
				wp_q[idx]   <= (wp_sel == PTR_W'(PIPE_BYTES - 1)) ? '0 : wp_sel + 1'b1;
				fill_q[idx] <= fill_sel + 1'b1;
			end
			if (do_close || do_ref) begin
				rref_q[idx] <= rref_nxt;
				wref_q[idx] <= wref_nxt;
			end
			if (do_close && rref_nxt == '0 && wref_nxt == '0) begin
				in_use_q[idx] <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			status_s1    <= ST_OK;
			new_index_s1 <= '0;
			rd_ok_s1     <= 1'b0;
		end else if (accept) begin
			valid_s1     <= 1'b1;
			status_s1    <= st;
			new_index_s1 <= do_create ? NEWIX_W'(free_idx) : '0;
			rd_ok_s1     <= do_read;
		end else if (response.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign response.valid     = valid_s1;
	assign response.status    = status_s1;
	assign response.new_index = new_index_s1;
	assign response.read_data = rd_ok_s1 ? mem_rdata : '0;

	`ASSERT_NEVER(a_mem_without_accept, clk, arst_n, mem_en && !accept)
	`ASSERT_CLK(a_read_result_follows, clk, arst_n, (accept && do_read) |=> (valid_s1 && rd_ok_s1))
	`ASSERT_CLK(a_stall_holds_result, clk, arst_n, !request.ready |-> valid_s1)

	for (genvar g = 0; g < NUM_PIPES; g++) begin : g_pipe_chk
		`ASSERT_CLK(a_free_pipe_clean, clk, arst_n, !in_use_q[g] |-> (rref_q[g] == '0 && wref_q[g] == '0))
		`ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q[g] > CNT_W'(PIPE_BYTES))
	end
endmodule

// ===== design/mpbf_store.sv =====
// single port byte memory holding the contents of all pipes
// synchronous read, data registered; depends on mpbf_pkg
`timescale 1ns / 1ps

module mpbf_store #(
	parameter int DEPTH  = mpbf_pkg::NUM_PIPES_DEF * mpbf_pkg::PIPE_BYTES_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         addr,
	input  logic [mpbf_pkg::DATA_W-1:0] wdata,
	output logic [mpbf_pkg::DATA_W-1:0] rdata
);
	import mpbf_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end
endmodule

// ===== tb/tb.sv =====
// testbench for multi_pipe_byte_fifo_table_top: directed and random command traffic,
// checked against a behavioral copy of the pipe table
// depends on mpbf_pkg, mpbf_in_if, mpbf_out_if and the block's rtl
`timescale 1ns / 1ps

module tb;
	import mpbf_pkg::*;

	localparam int NUM_PIPES  = NUM_PIPES_DEF;
	localparam int PIPE_BYTES = PIPE_BYTES_DEF;
	localparam int PTR_W      = $clog2(PIPE_BYTES);
	localparam int FILL_W     = $clog2(PIPE_BYTES + 1);

	typedef struct packed {
		status_t            status;
		logic [NEWIX_W-1:0] new_index;
		logic [DATA_W-1:0]  read_data;
	} pipe_result_t;

	logic clk = 1'b0;
	logic arst_n;

	mpbf_in_if  req_if ();
	mpbf_out_if rsp_if ();

	multi_pipe_byte_fifo_table_top #(
		.NUM_PIPES  (NUM_PIPES),
		.PIPE_BYTES (PIPE_BYTES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_if),
		.response (rsp_if)
	);

	always #5 clk = ~clk;

	// shadow copy of the pipe table
	logic              pipe_used [NUM_PIPES];
	logic [DATA_W-1:0] pipe_mem  [NUM_PIPES][PIPE_BYTES];
	logic [PTR_W-1:0]  wr_ptr    [NUM_PIPES];
	logic [PTR_W-1:0]  rd_ptr    [NUM_PIPES];
	logic [FILL_W-1:0] fill      [NUM_PIPES];
	logic [REF_W-1:0]  rd_refs   [NUM_PIPES];
	logic [REF_W-1:0]  wr_refs   [NUM_PIPES];

	pipe_result_t pending_results[$];
	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;

	function automatic pipe_result_t apply_pipe_command(
		input logic [CMD_W-1:0]   cmd,
		input logic [INDEX_W-1:0] idx,
		input logic [DATA_W-1:0]  data,
		input logic               wend,
		input logic               first
	);
		pipe_result_t r;
		logic live;
		r.status    = ST_OK;
		r.new_index = '0;
		r.read_data = '0;
		live = 1'b0;
		if (idx < NUM_PIPES)
			live = pipe_used[idx];
		if (cmd == CMD_CREATE) begin
			r.status = ST_NOFREE;
			for (int i = 0; i < NUM_PIPES; i++) begin
				if (!pipe_used[i]) begin
					pipe_used[i] = 1'b1;
					wr_ptr[i]    = '0;
					rd_ptr[i]    = '0;
					fill[i]      = '0;
					rd_refs[i]   = REF_W'(1);
					wr_refs[i]   = REF_W'(1);
					r.new_index  = i[NEWIX_W-1:0];
					r.status     = ST_OK;
					break;
				end
			end
		end else if (cmd > CMD_ADD_REF || !live) begin
			r.status = ST_INVALID;
		end else if (cmd == CMD_READ) begin
			if (fill[idx] == 0) begin
				if (!first)
					r.status = ST_SHORT;
				else if (wr_refs[idx] == 0)
					r.status = ST_EOD;
				else
					r.status = ST_BLOCK;
			end else begin
				r.read_data = pipe_mem[idx][rd_ptr[idx]];
				rd_ptr[idx] = (rd_ptr[idx] == PIPE_BYTES - 1) ? '0 : rd_ptr[idx] + 1'b1;
				fill[idx]   = fill[idx] - 1'b1;
			end
		end else if (cmd == CMD_WRITE) begin
			if (rd_refs[idx] == 0) begin
				r.status = ST_BROKEN;
			end else if (fill[idx] >= PIPE_BYTES) begin
				r.status = ST_BLOCK;
			end else begin
				pipe_mem[idx][wr_ptr[idx]] = data;
				wr_ptr[idx] = (wr_ptr[idx] == PIPE_BYTES - 1) ? '0 : wr_ptr[idx] + 1'b1;
				fill[idx]   = fill[idx] + 1'b1;
			end
		end else if (cmd == CMD_CLOSE) begin
			if (wend) begin
				if (wr_refs[idx] != 0)
					wr_refs[idx] = wr_refs[idx] - 1'b1;
			end else begin
				if (rd_refs[idx] != 0)
					rd_refs[idx] = rd_refs[idx] - 1'b1;
			end
			if (rd_refs[idx] == 0 && wr_refs[idx] == 0)
				pipe_used[idx] = 1'b0;
		end else begin
			if (wend) begin
				if (wr_refs[idx] != REF_MAX)
					wr_refs[idx] = wr_refs[idx] + 1'b1;
			end else begin
				if (rd_refs[idx] != REF_MAX)
					rd_refs[idx] = rd_refs[idx] + 1'b1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// one command transaction; the expected result is queued at acceptance
	task automatic send_cmd(
		input logic [CMD_W-1:0]   cmd,
		input logic [INDEX_W-1:0] idx,
		input logic [DATA_W-1:0]  data,
		input logic               wend,
		input logic               first
	);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.command      <= cmd;
		req_if.pipe_index   <= idx;
		req_if.write_data   <= data;
		req_if.end_is_write <= wend;
		req_if.first_byte   <= first;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		pending_results.push_back(apply_pipe_command(cmd, idx, data, wend, first));
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic logic [INDEX_W-1:0] pick_used_pipe();
		int cand[$];
		for (int i = 0; i < NUM_PIPES; i++)
			if (pipe_used[i])
				cand.push_back(i);
		if (cand.size() == 0)
			return INDEX_W'($urandom_range(NUM_PIPES - 1));
		return INDEX_W'(cand[$urandom_range(cand.size() - 1)]);
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		pipe_result_t exp_r;
		if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_if.status !== exp_r.status)
					report_mismatch($sformatf("status got %0d want %0d",
						rsp_if.status, exp_r.status));
				if (rsp_if.new_index !== exp_r.new_index)
					report_mismatch($sformatf("new_index got %0d want %0d",
						rsp_if.new_index, exp_r.new_index));
				if (rsp_if.read_data !== exp_r.read_data)
					report_mismatch($sformatf("read_data got %02h want %02h",
						rsp_if.read_data, exp_r.read_data));
			end
		end
		rsp_if.ready <= (arst_n === 1'b1) && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic test_basic_commands();
		// unknown commands and bad indices
		send_cmd(3'd5, 4'd0, 8'h00, 1'b0, 1'b0);
		send_cmd(3'd6, 4'd0, 8'h00, 1'b0, 1'b0);
		send_cmd(3'd7, 4'd15, 8'hFF, 1'b1, 1'b1);
		send_cmd(CMD_READ, 4'd15, 8'h00, 1'b0, 1'b1);
		send_cmd(CMD_WRITE, INDEX_W'(NUM_PIPES), 8'h5A, 1'b0, 1'b0);
		// fill the table, then one more create
		repeat (NUM_PIPES + 1)
			send_cmd(CMD_CREATE, 4'd0, 8'h00, 1'b0, 1'b0);
		send_cmd(CMD_WRITE, 4'd0, 8'hFF, 1'b0, 1'b0);
		send_cmd(CMD_WRITE, 4'd0, 8'h00, 1'b0, 1'b0);
		send_cmd(CMD_READ, 4'd0, 8'h00, 1'b0, 1'b1);
		send_cmd(CMD_READ, 4'd0, 8'h00, 1'b0, 1'b0);
		send_cmd(CMD_READ, 4'd0, 8'h00, 1'b0, 1'b0);
		send_cmd(CMD_READ, 4'd0, 8'h00, 1'b0, 1'b1);
		// end of data after the writer goes away, close of an end already at zero
		send_cmd(CMD_CLOSE, 4'd0, 8'h00, 1'b1, 1'b0);
		send_cmd(CMD_READ, 4'd0, 8'h00, 1'b0, 1'b1);
		send_cmd(CMD_CLOSE, 4'd0, 8'h00, 1'b1, 1'b0);
		// broken pipe once the reader goes away
		send_cmd(CMD_CLOSE, 4'd1, 8'h00, 1'b0, 1'b0);
		send_cmd(CMD_WRITE, 4'd1, 8'hA5, 1'b0, 1'b0);
		// last close frees the pipe
		send_cmd(CMD_CLOSE, 4'd0, 8'h00, 1'b0, 1'b0);
		send_cmd(CMD_ADD_REF, 4'd0, 8'h00, 1'b0, 1'b0);
	endtask

	task automatic test_full_pipe();
		logic [INDEX_W-1:0] p;
		send_cmd(CMD_CREATE, 4'd0, 8'h00, 1'b0, 1'b0);
		p = INDEX_W'(pending_results[$].new_index);
		repeat (PIPE_BYTES)
			send_cmd(CMD_WRITE, p, DATA_W'($urandom_range(255)), 1'b0, 1'b0);
		send_cmd(CMD_WRITE, p, DATA_W'($urandom_range(255)), 1'b0, 1'b0);
		repeat (PIPE_BYTES)
			send_cmd(CMD_READ, p, 8'h00, 1'b0, 1'($urandom_range(1)));
		send_cmd(CMD_READ, p, 8'h00, 1'b0, 1'b1);
		// second pass, with the pointers already wrapped
		repeat (20) begin
			send_cmd(CMD_WRITE, p, DATA_W'($urandom_range(255)), 1'b0, 1'b0);
			if ($urandom_range(1))
				send_cmd(CMD_READ, p, 8'h00, 1'b0, 1'b1);
		end
		send_cmd(CMD_CLOSE, p, 8'h00, 1'b1, 1'b0);
		send_cmd(CMD_CLOSE, p, 8'h00, 1'b0, 1'b0);
	endtask

	task automatic test_ref_saturation();
		logic [INDEX_W-1:0] p;
		wait_drained();
		send_cmd(CMD_CREATE, 4'd0, 8'h00, 1'b0, 1'b0);
		p = INDEX_W'(pending_results[$].new_index);
		if (pending_results[$].status == ST_NOFREE)
			p = pick_used_pipe();
		repeat (256)
			send_cmd(CMD_ADD_REF, p, 8'h00, 1'b0, 1'b0);
		repeat (256)
			send_cmd(CMD_ADD_REF, p, 8'h00, 1'b1, 1'b0);
		send_cmd(CMD_WRITE, p, DATA_W'($urandom_range(255)), 1'b0, 1'b0);
		send_cmd(CMD_CLOSE, p, 8'h00, 1'b1, 1'b0);
		send_cmd(CMD_READ, p, 8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_random_traffic(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				wait_drained();
			pick = $urandom_range(99);
			if (pick < 10)
				send_cmd(CMD_CREATE, INDEX_W'($urandom_range(15)),
					DATA_W'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else if (pick < 45)
				send_cmd(CMD_WRITE, pick_used_pipe(), DATA_W'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else if (pick < 78)
				send_cmd(CMD_READ, pick_used_pipe(), DATA_W'($urandom_range(255)),
					1'($urandom_range(1)), $urandom_range(9) != 0);
			else if (pick < 86)
				send_cmd(CMD_CLOSE, pick_used_pipe(), DATA_W'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else if (pick < 92)
				send_cmd(CMD_ADD_REF, pick_used_pipe(), DATA_W'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else
				send_cmd(CMD_W'($urandom_range(7)), INDEX_W'($urandom_range(15)),
					DATA_W'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		req_if.valid        = 1'b0;
		req_if.command      = CMD_CREATE;
		req_if.pipe_index   = '0;
		req_if.write_data   = '0;
		req_if.end_is_write = 1'b0;
		req_if.first_byte   = 1'b0;
		rsp_if.ready        = 1'b0;
		for (int i = 0; i < NUM_PIPES; i++) begin
			pipe_used[i] = 1'b0;
			wr_ptr[i]    = '0;
			rd_ptr[i]    = '0;
			fill[i]      = '0;
			rd_refs[i]   = '0;
			wr_refs[i]   = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 32;
		recv_idle_pct = 64;
		test_basic_commands();
		test_full_pipe();
		test_random_traffic(40);

		send_idle_pct = 64;
		recv_idle_pct = 32;
		test_ref_saturation();
		test_random_traffic(40);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(40);

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== multi_pipe_byte_fifo_table_top.f =====
+incdir+design
design/mpbf_pkg.sv
design/mpbf_in_if.sv
design/mpbf_out_if.sv
design/mpbf_store.sv
design/multi_pipe_byte_fifo_table_top.sv
tb/tb.sv
